// ----- sv/ilm_pkg.sv -----
// ilm_pkg: shared types, constants and scale functions for the level meter
// no dependencies; imported by the interfaces and every module

package ilm_pkg;

	// port count and derived index width
	localparam int PORTS  = 8;
	localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

	// field widths
	localparam int MODE_W  = 2;
	localparam int PORT_W  = 3;
	localparam int LEVEL_W = 16;
	localparam int HOLD_W  = 14;
	localparam int CNT_W   = 16;
	localparam int FS_W    = 11;
	localparam int N_W     = 19;
	localparam int CFG_IDX_W = 1;

	// shared multiplier widths
	localparam int MUL_A_W = 19;
	localparam int MUL_B_W = 20;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// reciprocals: x/25 = (x*RCP25)>>24, c/10 = (c*RCP10)>>19, exact over the used ranges
	localparam logic [MUL_B_W-1:0] RCP25 = 20'd671089;
	localparam logic [MUL_B_W-1:0] RCP10 = 20'd52429;

	// product slices
	localparam int Q_LO  = 12;  // N*fs / 4096
	localparam int Q_W   = 18;
	localparam int V_LO  = 24;  // q / 25
	localparam int BD_LO = 19;  // count / 10
	localparam int PD_LO = 20;  // count / 20

	// reset values and limits
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'h9C00;  // -100 dB
	localparam logic [FS_W-1:0]    FS_RESET    = 11'd100;
	localparam logic [HOLD_W-1:0]  V_MAX       = 14'd8659;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;

	// item modes
	localparam logic [MODE_W-1:0] MODE_STORE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEAK_CLR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_FALLOFF = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_MUL_FS,
		ST_MUL_RCP,
		ST_MUL_BAR,
		ST_MUL_PEAK,
		ST_UPD
	} state_t;

	typedef enum logic [1:0] {
		MS_N_FS,
		MS_Q_RCP,
		MS_BAR,
		MS_PEAK
	} mul_sel_t;

	typedef struct packed {
		logic              busy;
		logic              mul_en;
		mul_sel_t          mul_sel;
		logic              load_map;
		logic              load_v;
		logic              load_bdrop;
		logic              upd_fire;
		logic [PIDX_W-1:0] idx;
		logic              last;
	} ctrl_t;

	// six-segment scale numerator, deflection = N / 102400
	function automatic logic [N_W-1:0] scale_numer(input logic signed [LEVEL_W-1:0] d);
		logic signed [20:0] x;
		logic signed [23:0] n;
		x = 21'(d);
		if (d < -16'sd17920) begin
			n = 24'sd0;
		end else if (d < -16'sd15360) begin
			n = 24'(x + 21'sd17920);
		end else if (d < -16'sd12800) begin
			n = 24'(x + 21'sd15360) * 24'sd2 + 24'sd2560;
		end else if (d < -16'sd10240) begin
			n = 24'(x + 21'sd12800) * 24'sd3 + 24'sd7680;
		end else if (d < -16'sd7680) begin
			n = 24'(x + 21'sd10240) * 24'sd6 + 24'sd15360;
		end else if (d < -16'sd5120) begin
			n = 24'(x + 21'sd7680) * 24'sd8 + 24'sd30720;
		end else begin
			n = 24'(x + 21'sd5120) * 24'sd10 + 24'sd51200;
		end
		return n[N_W-1:0];
	endfunction

	// saturating decay counter step
	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + CNT_W'(1);
	endfunction

endpackage

// ----- sv/ilm_ifs.sv -----
// ilm_ifs: valid/ready channel interfaces for items, results and config writes
// depends on ilm_pkg

interface ilm_in_if import ilm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic [PORT_W-1:0]         port;
	logic signed [LEVEL_W-1:0] level_db;

	modport source (output valid, output mode, output port, output level_db, input ready);
	modport sink (input valid, input mode, input port, input level_db, output ready);
endinterface

interface ilm_out_if import ilm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PORT_W-1:0] port_index;
	logic [HOLD_W-1:0] bar_height;
	logic [HOLD_W-1:0] peak_height;
	logic              last;

	modport source (output valid, output port_index, output bar_height, output peak_height,
		output last, input ready);
	modport sink (input valid, input port_index, input bar_height, input peak_height,
		input last, output ready);
endinterface

interface ilm_cfg_if import ilm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FS_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/ilm_mul.sv -----
// ilm_mul: shared unsigned multiplier with registered product
// depends on ilm_pkg

module ilm_mul import ilm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] prod
);

	// product holds while not enabled
	always_ff @(posedge clk) begin
		if (en) begin
			prod <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule

// ----- sv/ilm_ctrl.sv -----
// ilm_ctrl: per-port sequencer for a tick, drives the shared multiplier steps
// depends on ilm_pkg

module ilm_ctrl import ilm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tick_start,
	input  logic  out_free,
	output ctrl_t ctl
);

	state_t            state_q, state_d;
	logic [PIDX_W-1:0] idx_q;
	logic              last_port;

	assign last_port = (idx_q == PIDX_W'(PORTS - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// port counter, advances on each delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.upd_fire) begin
			idx_q <= last_port ? '0 : idx_q + PIDX_W'(1);
		end
	end

	// next state and step controls
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ctl.idx  = idx_q;
		ctl.last = last_port;
		ctl.busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (tick_start) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				ctl.load_map = 1'b1;
				state_d      = ST_MUL_FS;
			end
			ST_MUL_FS: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_N_FS;
				state_d     = ST_MUL_RCP;
			end
			ST_MUL_RCP: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_Q_RCP;
				state_d     = ST_MUL_BAR;
			end
			ST_MUL_BAR: begin
				ctl.load_v  = 1'b1;
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = MS_BAR;
				state_d     = ST_MUL_PEAK;
			end
			ST_MUL_PEAK: begin
				ctl.load_bdrop = 1'b1;
				ctl.mul_en     = 1'b1;
				ctl.mul_sel    = MS_PEAK;
				state_d        = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					ctl.upd_fire = 1'b1;
					state_d      = last_port ? ST_IDLE : ST_MAP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a result for a non-final port moves the counter by one
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.upd_fire && !last_port) |=> (idx_q == $past(idx_q) + PIDX_W'(1)))
		else $error("port counter did not advance");

	// the final result ends the tick with the counter back at zero
	a_tick_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.upd_fire && last_port) |=> (state_q == ST_IDLE && idx_q == '0))
		else $error("tick did not close after final port");

	// a tick always starts at port zero
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && tick_start) |=> (state_q == ST_MAP && idx_q == '0))
		else $error("tick started off port zero");

endmodule

// ----- sv/iec_level_meter_ballistics.sv -----
// iec_level_meter_ballistics: top level, port state, hold update and channels
// depends on ilm_pkg, ilm_ifs, ilm_mul, ilm_ctrl
//
// Usage:
//   item channel: mode 0 stores level_db for one port, mode 1 runs a tick,
//   mode 2 clears all peak holds; mode 3 is dropped. Store, peak clear and
//   dropped items finish in the transfer cycle and give no result.
//   A tick gives one result per port, ports in ascending order, last set on
//   the final port. Each port runs a scale map, then four passes through
//   the one shared multiplier (times full_scale, divide by 102400, bar
//   count / 10, peak count / 20), then the hold update, which waits out
//   receiver stalls; the item channel is not ready until the final result
//   is in the output register.
//   Results leave through a one-entry output register; a stalled receiver
//   holds the sequencer in its update step and nothing is lost.
//   cfg channel: index 0 full_scale, index 1 peak_falloff_enable, always
//   ready; write only while no tick is running.
//   Reset: levels go to -100 dB, holds and decay counts to zero,
//   full_scale to 100, peak falloff enabled, output empty.

module iec_level_meter_ballistics import ilm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ilm_in_if.sink     item,
	ilm_out_if.source  result,
	ilm_cfg_if.sink    cfg
);

	ctrl_t ctl;

	logic [FS_W-1:0] fs_q;
	logic            pfe_q;

	logic [LEVEL_W-1:0] level_q [PORTS];
	logic [HOLD_W-1:0]  bar_q   [PORTS];
	logic [CNT_W-1:0]   bcnt_q  [PORTS];
	logic [HOLD_W-1:0]  peak_q  [PORTS];
	logic [CNT_W-1:0]   pcnt_q  [PORTS];

	logic [N_W-1:0]    n_q;
	logic [CNT_W-1:0]  binc_q, pinc_q;
	logic [HOLD_W-1:0] v_q, bdrop_q, pdrop;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	logic              item_fire, tick_start, store_hit, peak_clr;
	logic [PIDX_W-1:0] store_idx;
	logic              out_free;

	logic [HOLD_W-1:0] bar_cur, peak_cur, bar_new, peak_new;
	logic [CNT_W-1:0]  bcnt_new, pcnt_new;

	logic              res_valid_q, res_last_q;
	logic [PIDX_W-1:0] res_idx_q;
	logic [HOLD_W-1:0] res_bar_q, res_peak_q;

	// item transfer decode
	assign item.ready = !ctl.busy;
	assign item_fire  = item.valid && item.ready;
	assign tick_start = item_fire && (item.mode == MODE_TICK);
	assign store_hit  = item_fire && (item.mode == MODE_STORE) && (32'(item.port) < PORTS);
	assign peak_clr   = item_fire && (item.mode == MODE_PEAK_CLR);
	assign store_idx  = PIDX_W'(item.port);

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q  <= FS_RESET;
			pfe_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_FULL_SCALE) begin
				fs_q <= cfg.data;
			end else if (cfg.index == REG_PEAK_FALLOFF) begin
				pfe_q <= cfg.data[0];
			end
		end
	end

	// sequencer
	ilm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_start (tick_start),
		.out_free   (out_free),
		.ctl        (ctl)
	);

	// multiplier operand select
	always_comb begin
		unique case (ctl.mul_sel)
			MS_N_FS: begin
				mul_a = n_q;
				mul_b = MUL_B_W'(fs_q);
			end
			MS_Q_RCP: begin
				mul_a = MUL_A_W'(prod[Q_LO +: Q_W]);
				mul_b = RCP25;
			end
			MS_BAR: begin
				mul_a = MUL_A_W'(binc_q);
				mul_b = RCP10;
			end
			MS_PEAK: begin
				mul_a = MUL_A_W'(pinc_q);
				mul_b = RCP10;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ilm_mul u_mul (
		.clk  (clk),
		.en   (ctl.mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// per-port working registers
	always_ff @(posedge clk) begin
		if (ctl.load_map) begin
			n_q    <= scale_numer(level_q[ctl.idx]);
			binc_q <= count_up(bcnt_q[ctl.idx]);
			pinc_q <= count_up(pcnt_q[ctl.idx]);
		end
		if (ctl.load_v) begin
			v_q <= prod[V_LO +: HOLD_W];
		end
		if (ctl.load_bdrop) begin
			bdrop_q <= prod[BD_LO +: HOLD_W];
		end
	end

	assign pdrop = prod[PD_LO +: HOLD_W];

	// hold update for the current port
	assign bar_cur  = bar_q[ctl.idx];
	assign peak_cur = peak_q[ctl.idx];

	always_comb begin
		if (v_q > bar_cur) begin
			bar_new  = v_q;
			bcnt_new = '0;
		end else begin
			bcnt_new = binc_q;
			bar_new  = (bar_cur > bdrop_q) ? bar_cur - bdrop_q : '0;
		end
		if (v_q > peak_cur) begin
			peak_new = v_q;
			pcnt_new = '0;
		end else if (pfe_q) begin
			pcnt_new = pinc_q;
			peak_new = (peak_cur > pdrop) ? peak_cur - pdrop : '0;
		end else begin
			pcnt_new = pcnt_q[ctl.idx];
			peak_new = peak_cur;
		end
	end

	// port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				level_q[i] <= LEVEL_RESET;
				bar_q[i]   <= '0;
				bcnt_q[i]  <= '0;
				peak_q[i]  <= '0;
				pcnt_q[i]  <= '0;
			end
		end else begin
			if (store_hit) begin
				level_q[store_idx] <= item.level_db;
			end
			if (peak_clr) begin
				for (int i = 0; i < PORTS; i++) begin
					peak_q[i] <= '0;
				end
			end
			if (ctl.upd_fire) begin
				bar_q[ctl.idx]  <= bar_new;
				bcnt_q[ctl.idx] <= bcnt_new;
				peak_q[ctl.idx] <= peak_new;
				pcnt_q[ctl.idx] <= pcnt_new;
			end
		end
	end

	// output register
	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.upd_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd_fire) begin
			res_idx_q  <= ctl.idx;
			res_bar_q  <= bar_new;
			res_peak_q <= peak_new;
			res_last_q <= ctl.last;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.port_index  = PORT_W'(res_idx_q);
	assign result.bar_height  = res_bar_q;
	assign result.peak_height = res_peak_q;
	assign result.last        = res_last_q;

	// scaled value stays within the meter range
	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_v |=> (v_q <= V_MAX))
		else $error("scaled level out of range");

	// a new result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd_fire |-> (!res_valid_q || result.ready))
		else $error("result register overwritten");

	// a tick transfer locks out further items
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_start |=> (ctl.busy && !item.ready))
		else $error("item channel open during tick");

endmodule
